// ===== hw/rtl/swept_sphere_hit_test_macros.svh =====
// Assertion macros shared by the swept sphere hit test RTL.
`ifndef SWEPT_SPHERE_HIT_TEST_MACROS_SVH
`define SWEPT_SPHERE_HIT_TEST_MACROS_SVH

`ifndef ASSERT_OFF

`define SSH_ASSERT_IMPLY(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`define SSH_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SSH_ASSERT_IMPLY(name, clk, rstn, ante, cons)

`define SSH_ASSERT_NEXT(name, clk, rstn, ante, cons)

`endif

`endif

// ===== hw/rtl/ssh_pkg.sv =====
// Shared types and constants for the swept sphere hit test.
`default_nettype none

package ssh_pkg;

    localparam int COORD_W  = 32;
    localparam int RAD_W    = 31;
    localparam int FRAC_W   = 17;
    localparam int NORM_W   = 16;
    localparam int NORM_ONE = 16384;
    localparam int QDEPTH   = 2;

    typedef struct packed {
        logic            degen;
        logic [2:0]      m_neg;
        logic [2:0][31:0] m_mag;
        logic [2:0][32:0] w;
        logic [31:0]     rsum;
        logic [63:0]     msq;
    } ssh_entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/swept_sphere_hit_test.sv =====
// Top level of the swept sphere against static sphere hit test.
`default_nettype none

// One query is taken per clock (start high, busy low). Its result sits on the outputs
// for one cycle, marked by done; the receiver cannot hold results off. Between the
// accepting edge and done lie two front stages, the queue, the 138-stage back end (two
// 32-step square roots, the 29-step direction divider, the 17- and 15-step fraction
// and normal dividers and the arithmetic stages between them) and the output register.
// busy only rises if the front-to-back queue fills, which the always-draining back end
// never lets happen in practice.
module swept_sphere_hit_test import ssh_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic signed [COORD_W-1:0] start_x,
    input  wire logic signed [COORD_W-1:0] start_y,
    input  wire logic signed [COORD_W-1:0] start_z,
    input  wire logic signed [COORD_W-1:0] move_x,
    input  wire logic signed [COORD_W-1:0] move_y,
    input  wire logic signed [COORD_W-1:0] move_z,
    input  wire logic signed [COORD_W-1:0] center_x,
    input  wire logic signed [COORD_W-1:0] center_y,
    input  wire logic signed [COORD_W-1:0] center_z,
    input  wire logic        [RAD_W-1:0]   static_radius,
    input  wire logic        [RAD_W-1:0]   moving_radius,
    output logic                           done,
    output logic                           hit,
    output logic                           degenerate,
    output logic        [FRAC_W-1:0]       entry_frac,
    output logic signed [NORM_W-1:0]       normal_x,
    output logic signed [NORM_W-1:0]       normal_y,
    output logic signed [NORM_W-1:0]       normal_z
);

    logic       push_valid;
    ssh_entry_t push_data;
    logic       q_full;
    logic       pop_valid;
    ssh_entry_t pop_data;

    ssh_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .start_x       (start_x),
        .start_y       (start_y),
        .start_z       (start_z),
        .move_x        (move_x),
        .move_y        (move_y),
        .move_z        (move_z),
        .center_x      (center_x),
        .center_y      (center_y),
        .center_z      (center_z),
        .static_radius (static_radius),
        .moving_radius (moving_radius),
        .push_valid    (push_valid),
        .push_data     (push_data),
        .q_full        (q_full)
    );

    ssh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .full       (q_full),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data)
    );

    ssh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .done       (done),
        .hit        (hit),
        .degenerate (degenerate),
        .entry_frac (entry_frac),
        .normal_x   (normal_x),
        .normal_y   (normal_y),
        .normal_z   (normal_z)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/ssh_front.sv =====
// Front end: takes queries, forms offsets, squared move length and radius sum.
`default_nettype none

module ssh_front import ssh_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic signed [COORD_W-1:0] start_x,
    input  wire logic signed [COORD_W-1:0] start_y,
    input  wire logic signed [COORD_W-1:0] start_z,
    input  wire logic signed [COORD_W-1:0] move_x,
    input  wire logic signed [COORD_W-1:0] move_y,
    input  wire logic signed [COORD_W-1:0] move_z,
    input  wire logic signed [COORD_W-1:0] center_x,
    input  wire logic signed [COORD_W-1:0] center_y,
    input  wire logic signed [COORD_W-1:0] center_z,
    input  wire logic        [RAD_W-1:0]   static_radius,
    input  wire logic        [RAD_W-1:0]   moving_radius,
    output logic                           push_valid,
    output ssh_entry_t                     push_data,
    input  wire logic                      q_full
);

    logic             adv;
    logic             a_vld_reg;
    logic             b_vld_reg;
    logic [2:0][31:0] a_m_reg;
    logic [2:0][31:0] a_m_next;
    logic [2:0][32:0] a_w_reg;
    logic [2:0][32:0] a_w_next;
    logic [2:0][63:0] a_sq_reg;
    logic [2:0][63:0] a_sq_next;
    logic [31:0]      a_rsum_reg;
    logic [31:0]      a_rsum_next;
    ssh_entry_t       b_ent_reg;
    ssh_entry_t       b_ent_next;
    logic signed [COORD_W-1:0] s_vec [3];
    logic signed [COORD_W-1:0] m_vec [3];
    logic signed [COORD_W-1:0] c_vec [3];

    assign adv        = !(b_vld_reg && q_full);
    assign busy       = !adv;
    assign push_valid = b_vld_reg;
    assign push_data  = b_ent_reg;

    always_comb
    begin
        s_vec[0] = start_x;
        s_vec[1] = start_y;
        s_vec[2] = start_z;
        m_vec[0] = move_x;
        m_vec[1] = move_y;
        m_vec[2] = move_z;
        c_vec[0] = center_x;
        c_vec[1] = center_y;
        c_vec[2] = center_z;
        for (int i = 0; i < 3; i++)
        begin
            a_m_next[i]  = m_vec[i];
            a_w_next[i]  = 33'(c_vec[i]) - 33'(s_vec[i]);
            a_sq_next[i] = 64'(m_vec[i]) * 64'(m_vec[i]);
        end
        a_rsum_next = 32'(static_radius) + 32'(moving_radius);
    end

    always_comb
    begin
        b_ent_next.msq   = a_sq_reg[0] + a_sq_reg[1] + a_sq_reg[2];
        b_ent_next.rsum  = a_rsum_reg;
        b_ent_next.degen = (b_ent_next.msq == '0) || (a_rsum_reg == '0);
        b_ent_next.w     = a_w_reg;
        for (int i = 0; i < 3; i++)
        begin
            b_ent_next.m_neg[i] = a_m_reg[i][31];
            b_ent_next.m_mag[i] = a_m_reg[i][31] ? (~a_m_reg[i] + 32'd1) : a_m_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= start;
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_m_reg    <= a_m_next;
            a_w_reg    <= a_w_next;
            a_sq_reg   <= a_sq_next;
            a_rsum_reg <= a_rsum_next;
            b_ent_reg  <= b_ent_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ssh_queue.sv =====
// Short queue between the front end and the back end.
`default_nettype none
`include "swept_sphere_hit_test_macros.svh"

module ssh_queue import ssh_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push_valid,
    input  wire ssh_entry_t push_data,
    output logic            full,
    output logic            pop_valid,
    output ssh_entry_t      pop_data
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    ssh_entry_t       mem_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             empty;
    logic             push_acc;

    assign full      = (cnt_reg == CNT_W'(QDEPTH));
    assign empty     = (cnt_reg == '0);
    assign pop_valid = !empty;
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign push_acc  = push_valid && !full;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push_acc)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop_valid)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push_acc && !pop_valid)
            cnt_next = cnt_reg + 1'b1;
        else if (!push_acc && pop_valid)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_acc)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    `SSH_ASSERT_IMPLY(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(QDEPTH))
    `SSH_ASSERT_IMPLY(a_empty_ptrs, clk, rst_n, empty, wr_ptr_reg == rd_ptr_reg)
    `SSH_ASSERT_NEXT(a_push_holds, clk, rst_n, push_acc && !pop_valid, cnt_reg != '0)

endmodule

`default_nettype wire

// ===== hw/rtl/ssh_back.sv =====
// Back end: pipelined sqrt, direction, projection, entry, fraction and normal.
`default_nettype none
`include "swept_sphere_hit_test_macros.svh"

module ssh_back import ssh_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     pop_valid,
    input  wire ssh_entry_t               pop_data,
    output logic                          done,
    output logic                          hit,
    output logic                          degenerate,
    output logic        [FRAC_W-1:0]      entry_frac,
    output logic signed [NORM_W-1:0]      normal_x,
    output logic signed [NORM_W-1:0]      normal_y,
    output logic signed [NORM_W-1:0]      normal_z
);

    localparam int SQ1_LO  = 1;
    localparam int SQ1_HI  = 32;
    localparam int DV_INIT = 33;
    localparam int DV_LO   = 34;
    localparam int DV_HI   = 61;
    localparam int DIR_ST  = 62;
    localparam int WD_ST   = 63;
    localparam int ACC_ST  = 64;
    localparam int PROJ_ST = 65;
    localparam int DP_ST   = 66;
    localparam int Q_ST    = 67;
    localparam int QSQ_ST  = 68;
    localparam int D2_ST   = 69;
    localparam int SQ2_LO  = 70;
    localparam int SQ2_HI  = 101;
    localparam int H_ST    = 102;
    localparam int E_ST    = 103;
    localparam int NUM_ST  = 104;
    localparam int FR_INIT = 105;
    localparam int FR_LO   = 106;
    localparam int FR_HI   = 121;
    localparam int NR_INIT = 122;
    localparam int NR_LO   = 123;
    localparam int NR_HI   = 137;
    localparam int LAST    = 137;

    typedef struct packed {
        logic             degen;
        logic             miss;
        logic [2:0]       m_neg;
        logic [2:0][31:0] m_mag;
        logic [2:0][32:0] w;
        logic [31:0]      rsum;
        logic [31:0]      len;
        logic [63:0]      sq_rem;
        logic [31:0]      sq_root;
        logic [2:0][32:0] dv_rem;
        logic [2:0][28:0] dv_quo;
        logic [2:0][29:0] dir;
        logic [2:0][65:0] prod;
        logic [65:0]      acc;
        logic [35:0]      proj;
        logic [2:0][35:0] q;
        logic [2:0][63:0] qsq;
        logic [63:0]      r2;
        logic [36:0]      ent_ofs;
        logic [2:0][37:0] e;
        logic [2:0][51:0] num;
        logic [2:0]       clamp;
        logic [16:0]      frac;
    } ctx_t;

    // divide by 2^28, rounding half away from zero
    function automatic logic signed [65:0] rnd28(input logic signed [65:0] x);
        logic [65:0] mg;
        logic [65:0] rm;
        mg = x[65] ? 66'(-x) : 66'(x);
        rm = (mg + (66'd1 << 27)) >> 28;
        return x[65] ? $signed(-rm) : $signed(rm);
    endfunction

    function automatic ctx_t stage_fn(input ctx_t c, input int idx);
        ctx_t                n;
        int                  k;
        int                  b;
        logic [65:0]         t;
        logic [32:0]         r;
        logic signed [65:0]  sv;
        logic [65:0]         mg;
        logic [65:0]         d2;
        logic [36:0]         dv;
        logic [37:0]         em;
        logic [35:0]         qm;
        logic                ge;
        n = c;
        case (idx) inside
            [SQ1_LO:SQ1_HI], [SQ2_LO:SQ2_HI]:
            begin
                k = (idx <= SQ1_HI) ? (SQ1_HI - idx) : (SQ2_HI - idx);
                t = (66'(c.sq_root) << (k + 1)) + (66'd1 << (2 * k));
                if ({2'b00, c.sq_rem} >= t)
                begin
                    n.sq_rem  = c.sq_rem - t[63:0];
                    n.sq_root = c.sq_root | (32'd1 << k);
                end
            end
            DV_INIT:
            begin
                n.len = c.sq_root;
                for (int i = 0; i < 3; i++)
                begin
                    ge = c.m_mag[i] >= c.sq_root;
                    n.dv_rem[i] = ge ? {1'b0, c.m_mag[i] - c.sq_root} : {1'b0, c.m_mag[i]};
                    n.dv_quo[i] = '0;
                    n.dv_quo[i][28] = ge;
                end
            end
            [DV_LO:DV_HI]:
            begin
                b = DV_HI - idx;
                for (int i = 0; i < 3; i++)
                begin
                    r  = {c.dv_rem[i][31:0], 1'b0};
                    ge = r >= {1'b0, c.len};
                    n.dv_rem[i] = ge ? (r - {1'b0, c.len}) : r;
                    n.dv_quo[i][b] = ge;
                end
            end
            DIR_ST:
            begin
                for (int i = 0; i < 3; i++)
                    n.dir[i] = c.m_neg[i] ? -{1'b0, c.dv_quo[i]} : {1'b0, c.dv_quo[i]};
            end
            WD_ST:
            begin
                for (int i = 0; i < 3; i++)
                    n.prod[i] = 66'($signed(c.w[i])) * 66'($signed(c.dir[i]));
            end
            ACC_ST:
            begin
                n.acc = c.prod[0] + c.prod[1] + c.prod[2];
            end
            PROJ_ST:
            begin
                sv = rnd28($signed(c.acc));
                n.proj = sv[35:0];
            end
            DP_ST:
            begin
                for (int i = 0; i < 3; i++)
                    n.prod[i] = 66'($signed(c.dir[i])) * 66'($signed(c.proj));
            end
            Q_ST:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sv = 66'($signed(c.w[i])) - rnd28($signed(c.prod[i]));
                    n.q[i] = sv[35:0];
                    mg = sv[65] ? 66'(-sv) : 66'(sv);
                    if (mg > 66'(c.rsum))
                        n.miss = 1'b1;
                end
            end
            QSQ_ST:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    qm = c.q[i][35] ? -c.q[i] : c.q[i];
                    n.qsq[i] = 64'(qm[31:0]) * 64'(qm[31:0]);
                end
                n.r2 = 64'(c.rsum) * 64'(c.rsum);
            end
            D2_ST:
            begin
                d2 = 66'(c.qsq[0]) + 66'(c.qsq[1]) + 66'(c.qsq[2]);
                if (d2 > 66'(c.r2))
                    n.miss = 1'b1;
                n.sq_rem  = c.r2 - d2[63:0];
                n.sq_root = '0;
            end
            H_ST:
            begin
                dv = {c.proj[35], c.proj} - {5'b0, c.sq_root};
                n.ent_ofs = dv;
                if (dv[36] || (dv[35:0] > 36'(c.len)))
                    n.miss = 1'b1;
                for (int i = 0; i < 3; i++)
                    n.prod[i] = 66'($signed(c.dir[i])) * 66'($signed({1'b0, c.sq_root}));
            end
            E_ST:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sv = -66'($signed(c.q[i])) - rnd28($signed(c.prod[i]));
                    n.e[i] = sv[37:0];
                end
            end
            NUM_ST:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    em = c.e[i][37] ? -c.e[i] : c.e[i];
                    n.num[i]   = (52'(em) << 14) + 52'(c.rsum >> 1);
                    n.clamp[i] = n.num[i] >= (52'(c.rsum) << 15);
                end
            end
            FR_INIT:
            begin
                ge = c.ent_ofs[31:0] >= c.len;
                n.dv_rem[0] = ge ? {1'b0, c.ent_ofs[31:0] - c.len} : {1'b0, c.ent_ofs[31:0]};
                n.dv_quo[0] = '0;
                n.dv_quo[0][16] = ge;
            end
            [FR_LO:FR_HI]:
            begin
                b  = FR_HI - idx;
                r  = {c.dv_rem[0][31:0], 1'b0};
                ge = r >= {1'b0, c.len};
                n.dv_rem[0] = ge ? (r - {1'b0, c.len}) : r;
                n.dv_quo[0][b] = ge;
            end
            NR_INIT:
            begin
                n.frac = c.dv_quo[0][16:0];
                for (int i = 0; i < 3; i++)
                begin
                    n.dv_rem[i] = c.num[i][47:15];
                    n.dv_quo[i] = '0;
                end
            end
            [NR_LO:NR_HI]:
            begin
                b = NR_HI - idx;
                for (int i = 0; i < 3; i++)
                begin
                    r  = {c.dv_rem[i][31:0], c.num[i][b]};
                    ge = r >= {1'b0, c.rsum};
                    n.dv_rem[i] = ge ? (r - {1'b0, c.rsum}) : r;
                    n.dv_quo[i][b] = ge;
                end
            end
            default:
            begin
                n = c;
            end
        endcase
        return n;
    endfunction

    ctx_t ctx_reg  [0:LAST];
    ctx_t ctx_next [0:LAST];
    logic [LAST:0] vld_reg;

    logic                     hit_next;
    logic [FRAC_W-1:0]        frac_next;
    logic [2:0][NORM_W-1:0]   nrm_next;
    logic                     done_reg;
    logic                     hit_reg;
    logic                     degenerate_reg;
    logic [FRAC_W-1:0]        frac_reg;
    logic [2:0][NORM_W-1:0]   nrm_reg;

    always_comb
    begin
        ctx_next[0]         = '0;
        ctx_next[0].degen   = pop_data.degen;
        ctx_next[0].m_neg   = pop_data.m_neg;
        ctx_next[0].m_mag   = pop_data.m_mag;
        ctx_next[0].w       = pop_data.w;
        ctx_next[0].rsum    = pop_data.rsum;
        ctx_next[0].sq_rem  = pop_data.msq;
    end

    for (genvar g = 1; g <= LAST; g++)
    begin : g_stage
        always_comb
        begin
            ctx_next[g] = stage_fn(ctx_reg[g-1], g);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i <= LAST; i++)
            ctx_reg[i] <= ctx_next[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAST-1:0], pop_valid};
    end

    always_comb
    begin
        logic [14:0] nq;
        logic [14:0] nv;
        hit_next  = !ctx_reg[LAST].degen && !ctx_reg[LAST].miss;
        frac_next = hit_next ? ctx_reg[LAST].frac : '0;
        for (int i = 0; i < 3; i++)
        begin
            nq = ctx_reg[LAST].dv_quo[i][14:0];
            nv = (ctx_reg[LAST].clamp[i] || (nq > 15'(NORM_ONE))) ? 15'(NORM_ONE) : nq;
            if (!hit_next)
                nrm_next[i] = '0;
            else if (ctx_reg[LAST].e[i][37])
                nrm_next[i] = -16'(nv);
            else
                nrm_next[i] = 16'(nv);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_reg[LAST];
    end

    always_ff @(posedge clk)
    begin
        hit_reg        <= hit_next;
        degenerate_reg <= ctx_reg[LAST].degen;
        frac_reg       <= frac_next;
        nrm_reg        <= nrm_next;
    end

    assign done       = done_reg;
    assign hit        = hit_reg;
    assign degenerate = degenerate_reg;
    assign entry_frac = frac_reg;
    assign normal_x   = $signed(nrm_reg[0]);
    assign normal_y   = $signed(nrm_reg[1]);
    assign normal_z   = $signed(nrm_reg[2]);

    `SSH_ASSERT_IMPLY(a_hit_not_degen, clk, rst_n, done_reg, !(hit_reg && degenerate_reg))
    `SSH_ASSERT_IMPLY(a_miss_zero, clk, rst_n, done_reg && !hit_reg, {frac_reg, nrm_reg} == '0)
    `SSH_ASSERT_NEXT(a_no_stall, clk, rst_n, vld_reg[0], vld_reg[1])

endmodule

`default_nettype wire
